/* sv/cvla_pkg.sv */
// Shared types, constants and arctangent table for the cell-parameter unit
`default_nettype none
package cvla_pkg;

	// three lattice vectors, three angle lanes
	localparam int NV = 3;

	// fixed-point constants
	localparam logic signed [35:0] PI_Q30     = 36'sd3373259426;
	localparam logic [31:0]        ONE_Q30    = 32'h4000_0000;
	localparam logic [63:0]        ONE_SQ_Q60 = 64'h1000_0000_0000_0000;
	localparam logic [30:0]        LEN_MAX    = 31'h7FFF_FFFF;
	localparam logic signed [35:0] ROUND_HALF = 36'sd8192;

	// side data riding through the first square-root unit
	typedef struct packed {
		logic [NV-1:0]       zero;
		logic [NV-1:0][4:0]  shift;
		logic [NV-1:0]       negc;
		logic [NV-1:0][63:0] mag;
	} norm_side_t;

	// per-item data needed only at the output
	typedef struct packed {
		logic [NV-1:0]       zero;
		logic [NV-1:0]       negc;
		logic [NV-1:0][30:0] len;
	} tail_t;

	// side data riding through the sine square-root unit
	typedef struct packed {
		tail_t               tail;
		logic [NV-1:0][30:0] cosv;
	} sine_side_t;

	// arctangent of 2^-i in Q30
	function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
		logic signed [33:0] r;
		case (idx)
			5'd0:    r = 34'sd843314857;
			5'd1:    r = 34'sd497837829;
			5'd2:    r = 34'sd263043837;
			5'd3:    r = 34'sd133525159;
			5'd4:    r = 34'sd67021687;
			5'd5:    r = 34'sd33543516;
			5'd6:    r = 34'sd16775851;
			5'd7:    r = 34'sd8388437;
			5'd8:    r = 34'sd4194283;
			5'd9:    r = 34'sd2097149;
			5'd10:   r = 34'sd1048576;
			5'd11:   r = 34'sd524288;
			5'd12:   r = 34'sd262144;
			5'd13:   r = 34'sd131072;
			5'd14:   r = 34'sd65536;
			5'd15:   r = 34'sd32768;
			5'd16:   r = 34'sd16384;
			5'd17:   r = 34'sd8192;
			5'd18:   r = 34'sd4096;
			5'd19:   r = 34'sd2048;
			5'd20:   r = 34'sd1024;
			5'd21:   r = 34'sd512;
			5'd22:   r = 34'sd256;
			5'd23:   r = 34'sd128;
			5'd24:   r = 34'sd64;
			5'd25:   r = 34'sd32;
			5'd26:   r = 34'sd16;
			5'd27:   r = 34'sd8;
			5'd28:   r = 34'sd4;
			5'd29:   r = 34'sd2;
			5'd30:   r = 34'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

/* sv/cvla_sqrt.sv */
// Pipelined integer square root, three lanes, one result bit per stage
`default_nettype none
module cvla_sqrt #(
	parameter int SIDE_W = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic [SIDE_W-1:0]                in_side,
	input  logic [cvla_pkg::NV-1:0][63:0]    radicand,
	output logic                             out_valid,
	output logic [SIDE_W-1:0]                out_side,
	output logic [cvla_pkg::NV-1:0][31:0]    root
);
	import cvla_pkg::*;

	localparam int STEPS = 32;

	logic              valid_s [STEPS+1];
	logic [SIDE_W-1:0] side_s  [STEPS+1];
	logic [63:0]       op_s    [NV][STEPS];
	logic [33:0]       rem_s   [NV][STEPS];
	logic [31:0]       root_s  [NV][STEPS+1];

	assign valid_s[0] = in_valid;
	assign side_s[0]  = in_side;

	// valid and side data follow the lanes
	for (genvar k = 0; k < STEPS; k++) begin : g_ctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_s[k];
			end
		end
		always_ff @(posedge clk) begin
			side_s[k+1] <= side_s[k];
		end
	end

	for (genvar l = 0; l < NV; l++) begin : g_lane
		assign op_s[l][0]   = radicand[l];
		assign rem_s[l][0]  = '0;
		assign root_s[l][0] = '0;

		for (genvar k = 0; k < STEPS; k++) begin : g_step
			logic [35:0] acc;
			logic [35:0] trial;
			logic        take;

			// bring in two radicand bits, try root*4+1
			assign acc   = {rem_s[l][k], op_s[l][k][63:62]};
			assign trial = {2'b00, root_s[l][k], 2'b01};
			assign take  = (acc >= trial);

			always_ff @(posedge clk) begin
				root_s[l][k+1] <= {root_s[l][k][30:0], take};
			end

			if (k < STEPS-1) begin : g_carry
				always_ff @(posedge clk) begin
					op_s[l][k+1] <= {op_s[l][k][61:0], 2'b00};
					if (take) begin
						rem_s[l][k+1] <= 34'(acc - trial);
					end else begin
						rem_s[l][k+1] <= acc[33:0];
					end
				end
			end
		end

		assign root[l] = root_s[l][STEPS];
	end

	assign out_valid = valid_s[STEPS];
	assign out_side  = side_s[STEPS];

endmodule
`default_nettype wire

/* sv/cvla_div.sv */
// Pipelined restoring divider for the cosine quotient, three lanes
`default_nettype none
module cvla_div #(
	parameter int SIDE_W = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic [SIDE_W-1:0]                in_side,
	input  logic [cvla_pkg::NV-1:0][63:0]    num,
	input  logic [cvla_pkg::NV-1:0][63:0]    den,
	output logic                             out_valid,
	output logic [SIDE_W-1:0]                out_side,
	output logic [cvla_pkg::NV-1:0][31:0]    quo
);
	import cvla_pkg::*;

	// quotient of (num * 2^30) / den stays below 2^32
	localparam int STEPS = 32;

	logic              valid_s [STEPS+1];
	logic [SIDE_W-1:0] side_s  [STEPS+1];
	logic [63:0]       den_s   [NV][STEPS];
	logic [63:0]       rem_s   [NV][STEPS];
	logic [31:0]       bits_s  [NV][STEPS];
	logic [31:0]       quo_s   [NV][STEPS+1];

	assign valid_s[0] = in_valid;
	assign side_s[0]  = in_side;

	for (genvar k = 0; k < STEPS; k++) begin : g_ctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_s[k];
			end
		end
		always_ff @(posedge clk) begin
			side_s[k+1] <= side_s[k];
		end
	end

	for (genvar l = 0; l < NV; l++) begin : g_lane
		// upper 62 numerator bits seed the remainder, the low two and 30 zeros are shifted in
		assign den_s[l][0]  = den[l];
		assign rem_s[l][0]  = {2'b00, num[l][63:2]};
		assign bits_s[l][0] = {num[l][1:0], 30'b0};
		assign quo_s[l][0]  = '0;

		for (genvar k = 0; k < STEPS; k++) begin : g_step
			logic [64:0] acc;
			logic [64:0] dvs;
			logic        take;

			assign acc  = {rem_s[l][k], bits_s[l][k][31]};
			assign dvs  = {1'b0, den_s[l][k]};
			assign take = (acc >= dvs);

			always_ff @(posedge clk) begin
				quo_s[l][k+1] <= {quo_s[l][k][30:0], take};
			end

			if (k < STEPS-1) begin : g_carry
				always_ff @(posedge clk) begin
					den_s[l][k+1]  <= den_s[l][k];
					bits_s[l][k+1] <= {bits_s[l][k][30:0], 1'b0};
					if (take) begin
						rem_s[l][k+1] <= 64'(acc - dvs);
					end else begin
						rem_s[l][k+1] <= acc[63:0];
					end
				end
			end
		end

		assign quo[l] = quo_s[l][STEPS];
	end

	assign out_valid = valid_s[STEPS];
	assign out_side  = side_s[STEPS];

endmodule
`default_nettype wire

/* sv/cvla_cordic.sv */
// Pipelined vectoring CORDIC giving the arctangent of (sine, cosine), three lanes
`default_nettype none
module cvla_cordic #(
	parameter int SIDE_W = 8
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	input  logic [SIDE_W-1:0]                       in_side,
	input  logic [cvla_pkg::NV-1:0][30:0]           xin,
	input  logic [cvla_pkg::NV-1:0][31:0]           yin,
	output logic                                    out_valid,
	output logic [SIDE_W-1:0]                       out_side,
	output logic [cvla_pkg::NV-1:0][33:0]           zout
);
	import cvla_pkg::*;

	localparam int STEPS = 31;

	logic               valid_s [STEPS+1];
	logic [SIDE_W-1:0]  side_s  [STEPS+1];
	logic signed [33:0] x_s     [NV][STEPS];
	logic signed [33:0] y_s     [NV][STEPS];
	logic signed [33:0] z_s     [NV][STEPS+1];

	assign valid_s[0] = in_valid;
	assign side_s[0]  = in_side;

	for (genvar k = 0; k < STEPS; k++) begin : g_ctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_s[k];
			end
		end
		always_ff @(posedge clk) begin
			side_s[k+1] <= side_s[k];
		end
	end

	for (genvar l = 0; l < NV; l++) begin : g_lane
		assign x_s[l][0] = {3'b000, xin[l]};
		assign y_s[l][0] = {2'b00, yin[l]};
		assign z_s[l][0] = '0;

		for (genvar k = 0; k < STEPS; k++) begin : g_step
			localparam logic signed [33:0] ATAN_K = atan_q30(5'(k));
			logic signed [33:0] xs;
			logic signed [33:0] ys;
			logic               up;

			// rotate towards the x axis, y of zero counts as below
			assign xs = x_s[l][k] >>> k;
			assign ys = y_s[l][k] >>> k;
			assign up = (y_s[l][k] > 34'sd0);

			always_ff @(posedge clk) begin
				if (up) begin
					z_s[l][k+1] <= z_s[l][k] + ATAN_K;
				end else begin
					z_s[l][k+1] <= z_s[l][k] - ATAN_K;
				end
			end

			if (k < STEPS-1) begin : g_carry
				always_ff @(posedge clk) begin
					if (up) begin
						x_s[l][k+1] <= x_s[l][k] + ys;
						y_s[l][k+1] <= y_s[l][k] - xs;
					end else begin
						x_s[l][k+1] <= x_s[l][k] - ys;
						y_s[l][k+1] <= y_s[l][k] + xs;
					end
				end
			end
		end

		assign zout[l] = z_s[l][STEPS];
	end

	assign out_valid = valid_s[STEPS];
	assign out_side  = side_s[STEPS];

endmodule
`default_nettype wire

/* sv/cell_vectors_to_lengths_angles_unit.sv */
// Lattice vectors to cell lengths and angles, top level
//
// Takes one cell (three Q16.16 vectors) per clock and returns the three lengths and
// the three inter-vector angles, strobed by done for one cycle. busy is always low,
// so a new cell may be started on every clock. The pipeline is a chain of digit
// recurrences: a 32-stage square root for the norms, a 32-stage divider for the
// cosine, a 32-stage square root for the sine and a 31-stage CORDIC for the
// arctangent, plus eight stages of products, sums, normalisation and output
// rounding. Results cannot be held off; the receiver must take each one in the
// cycle it appears. A zero vector sets degenerate and forces the two angles that
// use it to zero.
`default_nettype none
module cell_vectors_to_lengths_angles_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] vec1_x,
	input  logic signed [31:0] vec1_y,
	input  logic signed [31:0] vec1_z,
	input  logic signed [31:0] vec2_x,
	input  logic signed [31:0] vec2_y,
	input  logic signed [31:0] vec2_z,
	input  logic signed [31:0] vec3_x,
	input  logic signed [31:0] vec3_y,
	input  logic signed [31:0] vec3_z,
	output logic               done,
	output logic [30:0]        length_a,
	output logic [30:0]        length_b,
	output logic [30:0]        length_c,
	output logic [17:0]        angle_alpha,
	output logic [17:0]        angle_beta,
	output logic [17:0]        angle_gamma,
	output logic               degenerate
);
	import cvla_pkg::*;

	// angle lanes: alpha (2nd,3rd), beta (3rd,1st), gamma (1st,2nd)
	localparam int PA [NV] = '{1, 2, 0};
	localparam int PB [NV] = '{2, 0, 1};

	localparam int NORM_W = $bits(norm_side_t);
	localparam int TAIL_W = $bits(tail_t);
	localparam int SINE_W = $bits(sine_side_t);

	logic signed [31:0] vin [NV][3];

	assign vin[0][0] = vec1_x;
	assign vin[0][1] = vec1_y;
	assign vin[0][2] = vec1_z;
	assign vin[1][0] = vec2_x;
	assign vin[1][1] = vec2_y;
	assign vin[1][2] = vec2_z;
	assign vin[2][0] = vec3_x;
	assign vin[2][1] = vec3_y;
	assign vin[2][2] = vec3_z;

	assign busy = 1'b0;

	// ---------------- stage 1: squares and dot-product terms
	logic signed [63:0] sq_c [NV][3];
	logic signed [63:0] dp_c [NV][3];
	logic               valid_s1;
	logic [62:0]        sq_s1 [NV][3];
	logic signed [63:0] dp_s1 [NV][3];
	logic [NV-1:0]      zero_s1;

	always_comb begin
		for (int v = 0; v < NV; v++) begin
			for (int j = 0; j < 3; j++) begin
				sq_c[v][j] = vin[v][j] * vin[v][j];
				dp_c[v][j] = vin[PA[v]][j] * vin[PB[v]][j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		for (int v = 0; v < NV; v++) begin
			for (int j = 0; j < 3; j++) begin
				sq_s1[v][j] <= sq_c[v][j][62:0];
				dp_s1[v][j] <= dp_c[v][j];
			end
			zero_s1[v] <= (vin[v][0] == '0) && (vin[v][1] == '0) && (vin[v][2] == '0);
		end
	end

	// ---------------- stage 2: squared norms and dot products
	logic               valid_s2;
	logic [63:0]        norm_s2 [NV];
	logic signed [65:0] dot_s2  [NV];
	logic [NV-1:0]      zero_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int v = 0; v < NV; v++) begin
			norm_s2[v] <= 64'(sq_s1[v][0]) + 64'(sq_s1[v][1]) + 64'(sq_s1[v][2]);
			dot_s2[v]  <= 66'(dp_s1[v][0]) + 66'(dp_s1[v][1]) + 66'(dp_s1[v][2]);
		end
		zero_s2 <= zero_s1;
	end

	// ---------------- stage 3: dot magnitude, coarse normalisation
	logic [63:0]   nrm3_c [NV];
	logic [4:0]    sft3_c [NV];
	logic          valid_s3;
	logic [63:0]   nrm_s3 [NV];
	logic [4:0]    sft_s3 [NV];
	logic [63:0]   mag_s3 [NV];
	logic [NV-1:0] negc_s3;
	logic [NV-1:0] zero_s3;

	always_comb begin
		for (int v = 0; v < NV; v++) begin
			nrm3_c[v] = norm_s2[v];
			sft3_c[v] = '0;
			if (nrm3_c[v][63:32] == '0) begin
				nrm3_c[v] = {nrm3_c[v][31:0], 32'b0};
				sft3_c[v] = sft3_c[v] + 5'd16;
			end
			if (nrm3_c[v][63:48] == '0) begin
				nrm3_c[v] = {nrm3_c[v][47:0], 16'b0};
				sft3_c[v] = sft3_c[v] + 5'd8;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int v = 0; v < NV; v++) begin
			nrm_s3[v]  <= nrm3_c[v];
			sft_s3[v]  <= sft3_c[v];
			negc_s3[v] <= dot_s2[v][65];
			if (dot_s2[v][65]) begin
				mag_s3[v] <= 64'(-dot_s2[v]);
			end else begin
				mag_s3[v] <= dot_s2[v][63:0];
			end
		end
		zero_s3 <= zero_s2;
	end

	// ---------------- stage 4: fine normalisation to at least 2^62 for a nonzero norm
	logic [63:0] nrm4_c [NV];
	logic [4:0]  sft4_c [NV];
	norm_side_t  nside_s4;
	logic        valid_s4;
	logic [NV-1:0][63:0] nrm_s4;

	always_comb begin
		for (int v = 0; v < NV; v++) begin
			nrm4_c[v] = nrm_s3[v];
			sft4_c[v] = sft_s3[v];
			if (nrm4_c[v][63:56] == '0) begin
				nrm4_c[v] = {nrm4_c[v][55:0], 8'b0};
				sft4_c[v] = sft4_c[v] + 5'd4;
			end
			if (nrm4_c[v][63:60] == '0) begin
				nrm4_c[v] = {nrm4_c[v][59:0], 4'b0};
				sft4_c[v] = sft4_c[v] + 5'd2;
			end
			if (nrm4_c[v][63:62] == '0) begin
				nrm4_c[v] = {nrm4_c[v][61:0], 2'b0};
				sft4_c[v] = sft4_c[v] + 5'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int v = 0; v < NV; v++) begin
			nrm_s4[v]         <= nrm4_c[v];
			nside_s4.shift[v] <= sft4_c[v];
			nside_s4.mag[v]   <= mag_s3[v];
		end
		nside_s4.negc <= negc_s3;
		nside_s4.zero <= zero_s3;
	end

	// ---------------- norm square roots
	logic                nr_valid;
	logic [NORM_W-1:0]   nr_side_vec;
	norm_side_t          nr_side;
	logic [NV-1:0][31:0] nr_root;

	cvla_sqrt #(
		.SIDE_W(NORM_W)
	) u_norm_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s4),
		.in_side  (NORM_W'(nside_s4)),
		.radicand (nrm_s4),
		.out_valid(nr_valid),
		.out_side (nr_side_vec),
		.root     (nr_root)
	);

	assign nr_side = norm_side_t'(nr_side_vec);

	// ---------------- stage 5: lengths, divisor product, scaled dot
	logic [31:0] lsh_c [NV];
	logic        valid_s5;
	tail_t       tail_s5;
	logic [NV-1:0][63:0] num_s5;
	logic [NV-1:0][63:0] den_s5;

	always_comb begin
		for (int v = 0; v < NV; v++) begin
			lsh_c[v] = nr_root[v] >> nr_side.shift[v];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= nr_valid;
		end
	end

	always_ff @(posedge clk) begin
		for (int v = 0; v < NV; v++) begin
			tail_s5.len[v] <= lsh_c[v][31] ? LEN_MAX : lsh_c[v][30:0];
			den_s5[v] <= 64'(nr_root[PA[v]]) * 64'(nr_root[PB[v]]);
			num_s5[v] <= nr_side.mag[v] <<
				(6'(nr_side.shift[PA[v]]) + 6'(nr_side.shift[PB[v]]));
		end
		tail_s5.zero <= nr_side.zero;
		tail_s5.negc <= nr_side.negc;
	end

	// ---------------- cosine division
	logic                dv_valid;
	logic [TAIL_W-1:0]   dv_side_vec;
	tail_t               dv_side;
	logic [NV-1:0][31:0] dv_quo;

	cvla_div #(
		.SIDE_W(TAIL_W)
	) u_cos_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s5),
		.in_side  (TAIL_W'(tail_s5)),
		.num      (num_s5),
		.den      (den_s5),
		.out_valid(dv_valid),
		.out_side (dv_side_vec),
		.quo      (dv_quo)
	);

	assign dv_side = tail_t'(dv_side_vec);

	// ---------------- stage 6: clamp cosine to one, square it
	logic [30:0] cos_c [NV];
	logic        valid_s6;
	tail_t       tail_s6;
	logic [30:0] cos_s6 [NV];
	logic [61:0] csq_s6 [NV];

	always_comb begin
		for (int v = 0; v < NV; v++) begin
			cos_c[v] = (dv_quo[v] > ONE_Q30) ? ONE_Q30[30:0] : dv_quo[v][30:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else begin
			valid_s6 <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		for (int v = 0; v < NV; v++) begin
			cos_s6[v] <= cos_c[v];
			csq_s6[v] <= 62'(cos_c[v]) * 62'(cos_c[v]);
		end
		tail_s6 <= dv_side;
	end

	// ---------------- stage 7: one minus cosine squared
	logic                valid_s7;
	sine_side_t          sside_s7;
	logic [NV-1:0][63:0] rad_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		for (int v = 0; v < NV; v++) begin
			rad_s7[v]        <= ONE_SQ_Q60 - 64'(csq_s6[v]);
			sside_s7.cosv[v] <= cos_s6[v];
		end
		sside_s7.tail <= tail_s6;
	end

	// ---------------- sine square roots
	logic                sn_valid;
	logic [SINE_W-1:0]   sn_side_vec;
	sine_side_t          sn_side;
	logic [NV-1:0][31:0] sn_root;

	cvla_sqrt #(
		.SIDE_W(SINE_W)
	) u_sine_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s7),
		.in_side  (SINE_W'(sside_s7)),
		.radicand (rad_s7),
		.out_valid(sn_valid),
		.out_side (sn_side_vec),
		.root     (sn_root)
	);

	assign sn_side = sine_side_t'(sn_side_vec);

	// ---------------- arctangent
	logic                cd_valid;
	logic [TAIL_W-1:0]   cd_side_vec;
	tail_t               cd_side;
	logic [NV-1:0][33:0] cd_z;

	cvla_cordic #(
		.SIDE_W(TAIL_W)
	) u_atan (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sn_valid),
		.in_side  (TAIL_W'(sn_side.tail)),
		.xin      (sn_side.cosv),
		.yin      (sn_root),
		.out_valid(cd_valid),
		.out_side (cd_side_vec),
		.zout     (cd_z)
	);

	assign cd_side = tail_t'(cd_side_vec);

	// ---------------- stage 8: fold by cosine sign, clamp, round to Q2.16, mask zero vectors
	logic signed [35:0] ang_c [NV];
	logic signed [35:0] rnd_c [NV];
	logic               valid_s8;
	logic [30:0]        len_s8 [NV];
	logic [17:0]        ang_s8 [NV];
	logic               degen_s8;

	always_comb begin
		for (int v = 0; v < NV; v++) begin
			if (cd_side.negc[v]) begin
				ang_c[v] = PI_Q30 - 36'($signed(cd_z[v]));
			end else begin
				ang_c[v] = 36'($signed(cd_z[v]));
			end
			if (ang_c[v] < 36'sd0) begin
				ang_c[v] = '0;
			end
			if (ang_c[v] > PI_Q30) begin
				ang_c[v] = PI_Q30;
			end
			rnd_c[v] = ang_c[v] + ROUND_HALF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else begin
			valid_s8 <= cd_valid;
		end
	end

	always_ff @(posedge clk) begin
		for (int v = 0; v < NV; v++) begin
			len_s8[v] <= cd_side.len[v];
			if (cd_side.zero[PA[v]] || cd_side.zero[PB[v]]) begin
				ang_s8[v] <= '0;
			end else begin
				ang_s8[v] <= rnd_c[v][31:14];
			end
		end
		degen_s8 <= |cd_side.zero;
	end

	// result ports
	assign done        = valid_s8;
	assign length_a    = len_s8[0];
	assign length_b    = len_s8[1];
	assign length_c    = len_s8[2];
	assign angle_alpha = ang_s8[0];
	assign angle_beta  = ang_s8[1];
	assign angle_gamma = ang_s8[2];
	assign degenerate  = degen_s8;

endmodule
`default_nettype wire

/* sv/cvla_checker.sv */
// Port-level checks for the cell-parameter unit, bound to the top level
`default_nettype none
module cvla_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        busy,
	input logic        done,
	input logic [30:0] length_a,
	input logic [30:0] length_b,
	input logic [30:0] length_c,
	input logic [17:0] angle_alpha,
	input logic [17:0] angle_beta,
	input logic [17:0] angle_gamma,
	input logic        degenerate
);

	// the unit never refuses a start
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// a zero first vector flags the cell and clears both angles that use it
	a_zero_a: assert property (@(posedge clk) disable iff (!arst_n)
		done && (length_a == 31'd0) |-> degenerate && (angle_beta == 18'd0) &&
		(angle_gamma == 18'd0))
		else $error("zero first vector not handled");

	// the flag only comes with a zero length
	a_degen_len: assert property (@(posedge clk) disable iff (!arst_n)
		done && degenerate |-> (length_a == 31'd0) || (length_b == 31'd0) ||
		(length_c == 31'd0))
		else $error("degenerate without a zero length");

	// angles never pass pi
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (angle_alpha <= 18'd205887) && (angle_beta <= 18'd205887) &&
		(angle_gamma <= 18'd205887))
		else $error("angle above pi");

endmodule

bind cell_vectors_to_lengths_angles_unit cvla_checker u_cvla_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.busy       (busy),
	.done       (done),
	.length_a   (length_a),
	.length_b   (length_b),
	.length_c   (length_c),
	.angle_alpha(angle_alpha),
	.angle_beta (angle_beta),
	.angle_gamma(angle_gamma),
	.degenerate (degenerate)
);
`default_nettype wire
